### rtl/core/kcq_pkg.sv
// kcq_pkg: shared types and constants of the k-means color quantizer core
// no dependencies; imported by every module of the core
`default_nettype none

package kcq_pkg;

   localparam int MAX_PIXELS   = 65536;
   localparam int ADDR_W       = 16;
   localparam int TOTAL_W      = 17;
   localparam int MAX_CLUSTERS = 16;
   localparam int CL_W         = 4;
   localparam int KCNT_W       = 5;
   localparam int SUM_W        = 24;
   localparam int CEN_W        = 16;
   localparam int SQ_W         = 32;
   localparam int DIST_W       = 34;
   localparam int PIX_W        = 24;
   localparam int DIVD_W       = 32;

   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   localparam logic [1:0] CSR_CLUSTER_COUNT   = 2'd0;
   localparam logic [1:0] CSR_ITERATION_COUNT = 2'd1;
   localparam logic [1:0] CSR_LFSR_SEED       = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   typedef struct packed {
      logic                 start;
      logic [DIVD_W-1:0]    dividend;
      logic [TOTAL_W-1:0]   divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIVD_W-1:0]    quotient;
      logic [TOTAL_W-1:0]   remainder;
   } div_rsp_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [PIX_W-1:0]     data;
   } pix_wr_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [CL_W-1:0]      label;
   } lbl_wr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ_OUT,
      ST_SEED_STEP,
      ST_SEED_DIV,
      ST_SEED_READ,
      ST_SEED_WRITE,
      ST_PASS_START,
      ST_PASS_RUN,
      ST_PASS_DRAIN,
      ST_DIV_START,
      ST_DIV_WAIT
   } state_type;

endpackage

`default_nettype wire

### rtl/core/kcq_pixel_mem.sv
// kcq_pixel_mem: pixel store and pixel label memories, one write and one
// registered read port each; depends on kcq_pkg
`default_nettype none

module kcq_pixel_mem
   import kcq_pkg::*;
(
   input  wire logic              clock,
   input  wire pix_wr_type        pix_wr,
   input  wire logic [ADDR_W-1:0] pix_rd_addr,
   output logic [PIX_W-1:0]       pix_rd_data,
   input  wire lbl_wr_type        lbl_wr,
   input  wire logic [ADDR_W-1:0] lbl_rd_addr,
   output logic [CL_W-1:0]        lbl_rd_data
);

   logic [PIX_W-1:0] pix_mem [MAX_PIXELS];
   logic [CL_W-1:0]  lbl_mem [MAX_PIXELS];
   logic [PIX_W-1:0] pix_rd_ff;
   logic [CL_W-1:0]  lbl_rd_ff;

   always_ff @(posedge clock) begin
      if (pix_wr.en) begin
         pix_mem[pix_wr.addr] <= pix_wr.data;
      end
      pix_rd_ff <= pix_mem[pix_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (lbl_wr.en) begin
         lbl_mem[lbl_wr.addr] <= lbl_wr.label;
      end
      lbl_rd_ff <= lbl_mem[lbl_rd_addr];
   end

   assign pix_rd_data = pix_rd_ff;
   assign lbl_rd_data = lbl_rd_ff;

endmodule

`default_nettype wire

### rtl/core/kcq_divider.sv
// kcq_divider: restoring divider, one quotient bit per cycle
// depends on kcq_pkg for the request and response structs
`default_nettype none

module kcq_divider
   import kcq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   localparam int CNT_W = $clog2(DIVD_W);

   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0]  quo_ff, quo_in;
   logic [TOTAL_W-1:0] dsr_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff, done_ff;
   logic [TOTAL_W:0]   trial;
   logic               fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIVD_W-1]};
      fits   = (trial >= {1'b0, dsr_ff});
      rem_in = fits ? TOTAL_W'(trial - {1'b0, dsr_ff}) : trial[TOTAL_W-1:0];
      quo_in = {quo_ff[DIVD_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIVD_W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= '0;
         quo_ff <= req.dividend;
         dsr_ff <= req.divisor;
      end else if (run_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

### rtl/core/kmeans_color_quantizer_core.sv
// kmeans_color_quantizer_core: top level of the k-means color quantizer
// depends on kcq_pkg, kcq_pixel_mem and kcq_divider
`default_nettype none

// Loads leave busy low unless marked last, so pixels can stream in back to
// back. A load marked last raises busy for the whole clustering run: seeding
// runs, per cluster, one pass of the shared 32-step divider for lfsr mod
// count plus a pixel memory read, and each pass streams the pixels through
// the distance pipeline (one pixel memory read per cycle, all clusters
// compared in parallel), then divides each channel sum of every non-empty
// cluster on the same divider. A read that is invalid is answered straight
// from the request, a valid one after the label memory read, then the
// centroid lookup; its result shows on rsp_valid for exactly one cycle and
// cannot be held off, so the receiver must take it when it appears.
module kmeans_color_quantizer_core
   import kcq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   input  wire logic        req_last_pixel,
   input  wire logic [15:0] req_read_index,
   output logic             rsp_valid,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [3:0]       rsp_out_cluster,
   output logic             rsp_read_status,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   state_type state_ff, state_in;

   logic [KCNT_W-1:0]  kcfg_ff;
   logic [7:0]         iter_ff;
   logic [15:0]        lfsr_ff, lfsr_next;
   logic [TOTAL_W-1:0] total_ff, base;
   logic               done_ff;
   logic [CL_W-1:0]    cl_ff;
   logic [1:0]         ch_ff;
   logic [7:0]         pass_ff;
   logic [ADDR_W-1:0]  scan_ff, seed_addr_ff;

   logic [KCNT_W-1:0]  k_eff;
   logic [CL_W-1:0]    last_cl;
   logic [7:0]         pass_last;
   logic               accept, rd_ok, scan_end, pass_end, cl_end, zero_cnt;

   logic [CEN_W-1:0]   cen_ff [MAX_CLUSTERS][3];
   logic [SUM_W-1:0]   sum_ff [MAX_CLUSTERS][3];
   logic [TOTAL_W-1:0] cnt_ff [MAX_CLUSTERS];
   logic [SUM_W-1:0]   sum_sel;

   pix_wr_type         pix_wr;
   lbl_wr_type         lbl_wr;
   logic [ADDR_W-1:0]  pix_rd_addr;
   logic [PIX_W-1:0]   pix_rd_data;
   logic [CL_W-1:0]    lbl_rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // distance pipeline
   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [ADDR_W-1:0]  idx1_ff, idx2_ff, idx3_ff, idx4_ff, idx5_ff;
   logic [PIX_W-1:0]   pix2_ff, pix3_ff, pix4_ff, pix5_ff;
   logic [SQ_W-1:0]    sq_ff   [MAX_CLUSTERS][3];
   logic [15:0]        ad      [MAX_CLUSTERS][3];
   logic [DIST_W-1:0]  dist_ff [MAX_CLUSTERS];
   logic [DIST_W-1:0]  l1_d [8], l2_d [4], l3_d [2];
   logic [CL_W-1:0]    l1_i [8], l2_i [4], l3_i [2];
   logic               l1_v [8], l2_v [4], l3_v [2];
   logic [DIST_W-1:0]  b4_d_ff [4];
   logic [CL_W-1:0]    b4_i_ff [4];
   logic               b4_v_ff [4];
   logic [CL_W-1:0]    best_ff, best_in;
   logic               pipe_busy;

   logic               rsp_valid_ff, rsp_status_ff;
   logic [7:0]         rsp_r_ff, rsp_g_ff, rsp_b_ff;
   logic [3:0]         rsp_c_ff;

   kcq_pixel_mem u_mem (
      .clock       (clock),
      .pix_wr      (pix_wr),
      .pix_rd_addr (pix_rd_addr),
      .pix_rd_data (pix_rd_data),
      .lbl_wr      (lbl_wr),
      .lbl_rd_addr (req_read_index),
      .lbl_rd_data (lbl_rd_data)
   );

   kcq_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // configuration and derived counts
   always_comb begin
      if (kcfg_ff == '0) begin
         k_eff = KCNT_W'(1);
      end else if (kcfg_ff > KCNT_W'(MAX_CLUSTERS)) begin
         k_eff = KCNT_W'(MAX_CLUSTERS);
      end else begin
         k_eff = kcfg_ff;
      end
      last_cl   = CL_W'(k_eff - KCNT_W'(1));
      pass_last = (iter_ff == 8'd0) ? 8'd0 : iter_ff - 8'd1;
      lfsr_next = {1'b0, lfsr_ff[15:1]} ^ (lfsr_ff[0] ? LFSR_TAPS : 16'd0);
      busy      = (state_ff != ST_IDLE);
      accept    = start && !busy;
      base      = done_ff ? '0 : total_ff;
      rd_ok     = done_ff && ({1'b0, req_read_index} < total_ff);
      scan_end  = ({1'b0, scan_ff} == TOTAL_W'(total_ff - 1'b1));
      cl_end    = (cl_ff == last_cl);
      pass_end  = (pass_ff == pass_last);
      zero_cnt  = (cnt_ff[cl_ff] == '0);
      pipe_busy = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff;
      case (ch_ff)
         2'd0:    sum_sel = sum_ff[cl_ff][0];
         2'd1:    sum_sel = sum_ff[cl_ff][1];
         default: sum_sel = sum_ff[cl_ff][2];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_LOAD && req_last_pixel) begin
               state_in = ST_SEED_STEP;
            end else if (accept && req_command == CMD_READ && rd_ok) begin
               state_in = ST_READ_OUT;
            end
         end
         ST_READ_OUT:   state_in = ST_IDLE;
         ST_SEED_STEP:  state_in = ST_SEED_DIV;
         ST_SEED_DIV:   if (div_rsp.done) state_in = ST_SEED_READ;
         ST_SEED_READ:  state_in = ST_SEED_WRITE;
         ST_SEED_WRITE: state_in = cl_end ? ST_PASS_START : ST_SEED_STEP;
         ST_PASS_START: state_in = ST_PASS_RUN;
         ST_PASS_RUN:   if (scan_end) state_in = ST_PASS_DRAIN;
         ST_PASS_DRAIN: if (!pipe_busy) state_in = ST_DIV_START;
         ST_DIV_START: begin
            if (zero_cnt) begin
               if (cl_end) begin
                  state_in = pass_end ? ST_IDLE : ST_PASS_START;
               end
            end else begin
               state_in = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               if (ch_ff == 2'd2 && cl_end) begin
                  state_in = pass_end ? ST_IDLE : ST_PASS_START;
               end else begin
                  state_in = ST_DIV_START;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory and divider requests
   always_comb begin
      pix_wr.en   = accept && req_command == CMD_LOAD && !base[TOTAL_W-1];
      pix_wr.addr = base[ADDR_W-1:0];
      pix_wr.data = {req_blue_in, req_green_in, req_red_in};
      pix_rd_addr = (state_ff == ST_SEED_READ) ? seed_addr_ff : scan_ff;
      lbl_wr.en    = v5_ff;
      lbl_wr.addr  = idx5_ff;
      lbl_wr.label = best_ff;
      div_req.start    = (state_ff == ST_SEED_STEP) || (state_ff == ST_DIV_START && !zero_cnt);
      div_req.dividend = (state_ff == ST_SEED_STEP) ? {16'd0, lfsr_next} : {sum_sel, 8'd0};
      div_req.divisor  = (state_ff == ST_SEED_STEP) ? total_ff : cnt_ff[cl_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kcfg_ff  <= KCNT_W'(8);
         iter_ff  <= 8'd30;
         lfsr_ff  <= 16'd1;
         total_ff <= '0;
         done_ff  <= 1'b0;
         cl_ff    <= '0;
         ch_ff    <= '0;
         pass_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_CLUSTER_COUNT:   kcfg_ff <= csr_wdata[KCNT_W-1:0];
               CSR_ITERATION_COUNT: iter_ff <= csr_wdata[7:0];
               CSR_LFSR_SEED:       lfsr_ff <= (csr_wdata == 16'd0) ? 16'd1 : csr_wdata;
               default: ;
            endcase
         end
         if (accept && req_command == CMD_LOAD) begin
            done_ff  <= 1'b0;
            total_ff <= base[TOTAL_W-1] ? base : TOTAL_W'(base + 1'b1);
            cl_ff    <= '0;
            pass_ff  <= '0;
         end
         case (state_ff)
            ST_SEED_STEP: lfsr_ff <= lfsr_next;
            ST_SEED_WRITE: begin
               cl_ff <= cl_end ? '0 : cl_ff + 1'b1;
            end
            ST_PASS_START: scan_ff <= '0;
            ST_PASS_RUN: begin
               scan_ff <= scan_ff + 1'b1;
               cl_ff   <= '0;
               ch_ff   <= '0;
            end
            ST_DIV_START: begin
               if (zero_cnt) begin
                  ch_ff <= '0;
                  if (cl_end) begin
                     cl_ff   <= '0;
                     pass_ff <= pass_ff + 1'b1;
                     done_ff <= pass_end;
                  end else begin
                     cl_ff <= cl_ff + 1'b1;
                  end
               end
            end
            ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  if (ch_ff == 2'd2) begin
                     ch_ff <= '0;
                     if (cl_end) begin
                        cl_ff   <= '0;
                        pass_ff <= pass_ff + 1'b1;
                        done_ff <= pass_end;
                     end else begin
                        cl_ff <= cl_ff + 1'b1;
                     end
                  end else begin
                     ch_ff <= ch_ff + 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // centroid store, member sums and seed address
   always_ff @(posedge clock) begin
      if (state_ff == ST_SEED_DIV && div_rsp.done) begin
         seed_addr_ff <= div_rsp.remainder[ADDR_W-1:0];
      end
      if (state_ff == ST_SEED_WRITE) begin
         cen_ff[cl_ff][0] <= {pix_rd_data[7:0], 8'd0};
         cen_ff[cl_ff][1] <= {pix_rd_data[15:8], 8'd0};
         cen_ff[cl_ff][2] <= {pix_rd_data[23:16], 8'd0};
      end
      if (state_ff == ST_DIV_WAIT && div_rsp.done) begin
         case (ch_ff)
            2'd0:    cen_ff[cl_ff][0] <= div_rsp.quotient[CEN_W-1:0];
            2'd1:    cen_ff[cl_ff][1] <= div_rsp.quotient[CEN_W-1:0];
            default: cen_ff[cl_ff][2] <= div_rsp.quotient[CEN_W-1:0];
         endcase
      end
      if (state_ff == ST_PASS_START) begin
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            sum_ff[i][0] <= '0;
            sum_ff[i][1] <= '0;
            sum_ff[i][2] <= '0;
            cnt_ff[i]    <= '0;
         end
      end else if (v5_ff) begin
         sum_ff[best_ff][0] <= sum_ff[best_ff][0] + SUM_W'(pix5_ff[7:0]);
         sum_ff[best_ff][1] <= sum_ff[best_ff][1] + SUM_W'(pix5_ff[15:8]);
         sum_ff[best_ff][2] <= sum_ff[best_ff][2] + SUM_W'(pix5_ff[23:16]);
         cnt_ff[best_ff]    <= cnt_ff[best_ff] + 1'b1;
      end
   end

   // distance lanes: absolute differences per cluster and channel
   always_comb begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
         for (int c = 0; c < 3; c++) begin
            if ({pix_rd_data[8*c +: 8], 8'd0} >= cen_ff[i][c]) begin
               ad[i][c] = {pix_rd_data[8*c +: 8], 8'd0} - cen_ff[i][c];
            end else begin
               ad[i][c] = cen_ff[i][c] - {pix_rd_data[8*c +: 8], 8'd0};
            end
         end
      end
   end

   // min tree, ties keep the lower index
   always_comb begin
      for (int j = 0; j < 8; j++) begin
         l1_v[j] = 1'b1;
         if ((KCNT_W'(2*j+1) < k_eff) && (dist_ff[2*j+1] < dist_ff[2*j])) begin
            l1_d[j] = dist_ff[2*j+1];
            l1_i[j] = CL_W'(2*j+1);
         end else begin
            l1_d[j] = dist_ff[2*j];
            l1_i[j] = CL_W'(2*j);
            l1_v[j] = (KCNT_W'(2*j) < k_eff);
         end
      end
      for (int j = 0; j < 4; j++) begin
         if (l1_v[2*j+1] && (l1_d[2*j+1] < l1_d[2*j])) begin
            l2_d[j] = l1_d[2*j+1];
            l2_i[j] = l1_i[2*j+1];
            l2_v[j] = 1'b1;
         end else begin
            l2_d[j] = l1_d[2*j];
            l2_i[j] = l1_i[2*j];
            l2_v[j] = l1_v[2*j];
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (b4_v_ff[2*j+1] && (b4_d_ff[2*j+1] < b4_d_ff[2*j])) begin
            l3_d[j] = b4_d_ff[2*j+1];
            l3_i[j] = b4_i_ff[2*j+1];
            l3_v[j] = 1'b1;
         end else begin
            l3_d[j] = b4_d_ff[2*j];
            l3_i[j] = b4_i_ff[2*j];
            l3_v[j] = b4_v_ff[2*j];
         end
      end
      best_in = (l3_v[1] && (l3_d[1] < l3_d[0])) ? l3_i[1] : l3_i[0];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
         for (int c = 0; c < 3; c++) begin
            sq_ff[i][c] <= ad[i][c] * ad[i][c];
         end
         dist_ff[i] <= DIST_W'(sq_ff[i][0]) + DIST_W'(sq_ff[i][1]) + DIST_W'(sq_ff[i][2]);
      end
      for (int j = 0; j < 4; j++) begin
         b4_d_ff[j] <= l2_d[j];
         b4_i_ff[j] <= l2_i[j];
         b4_v_ff[j] <= l2_v[j];
      end
      best_ff <= best_in;
      idx1_ff <= scan_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      idx4_ff <= idx3_ff;
      idx5_ff <= idx4_ff;
      pix2_ff <= pix_rd_data;
      pix3_ff <= pix2_ff;
      pix4_ff <= pix3_ff;
      pix5_ff <= pix4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= (state_ff == ST_PASS_RUN);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // read transaction results
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (accept && req_command == CMD_READ && !rd_ok) ||
                         (state_ff == ST_READ_OUT);
      end
      if (accept && req_command == CMD_READ && !rd_ok) begin
         rsp_r_ff      <= '0;
         rsp_g_ff      <= '0;
         rsp_b_ff      <= '0;
         rsp_c_ff      <= '0;
         rsp_status_ff <= 1'b1;
      end else if (state_ff == ST_READ_OUT) begin
         rsp_r_ff      <= cen_ff[lbl_rd_data][0][15:8];
         rsp_g_ff      <= cen_ff[lbl_rd_data][1][15:8];
         rsp_b_ff      <= cen_ff[lbl_rd_data][2][15:8];
         rsp_c_ff      <= lbl_rd_data;
         rsp_status_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_red     = rsp_r_ff;
   assign rsp_out_green   = rsp_g_ff;
   assign rsp_out_blue    = rsp_b_ff;
   assign rsp_out_cluster = rsp_c_ff;
   assign rsp_read_status = rsp_status_ff;

   a_no_pipe_in_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_START || state_ff == ST_DIV_WAIT) |-> !pipe_busy)
      else $error("distance pipeline active during centroid division");

   a_label_in_range: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> ({1'b0, idx5_ff} < total_ff))
      else $error("label written beyond loaded pixel count");

   a_bad_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_read_status) |-> (rsp_out_cluster == 4'd0 && rsp_out_red == 8'd0))
      else $error("invalid read result carries data");

endmodule

`default_nettype wire
